### hw/rtl/tod_pkg.sv
// ----------------------------------------------------------------------------
// tod_pkg: shared types and constants of the synced time-of-day keeper
// Holds the item classes, status codes, queue item type and time constants.
// ----------------------------------------------------------------------------
package tod_pkg;

	localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;
	localparam logic [33:0] POSIX_AT_1990 = 34'd631152000;

	// Request types on the input channel.
	localparam logic [1:0] REQ_READ = 2'd0;
	localparam logic [1:0] REQ_SYNC = 2'd1;
	localparam logic [1:0] REQ_FAIL = 2'd2;
	localparam logic [1:0] REQ_NOP  = 2'd3;

	// Classes that the front end hands to the back end.
	localparam logic [2:0] CL_READ = 3'd0;
	localparam logic [2:0] CL_SYNC = 3'd1;
	localparam logic [2:0] CL_BAD  = 3'd2;
	localparam logic [2:0] CL_FAIL = 3'd3;
	localparam logic [2:0] CL_NOP  = 3'd4;

	// Result status codes.
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_NOSYNC   = 3'd1;
	localparam logic [2:0] STAT_FAILED   = 3'd2;
	localparam logic [2:0] STAT_BADTIME  = 3'd3;
	localparam logic [2:0] STAT_NOTLATER = 3'd4;

	// The remainder divide runs radix 4 over 18 digits (36 quotient bits).
	localparam logic [4:0] DIV_LAST = 5'd17;

	localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;

	typedef struct packed {
		logic [2:0]  cls;
		logic [31:0] tsec;
		logic [29:0] tns;
		logic [63:0] mono;
	} tod_item_t;

endpackage

### hw/rtl/tod_if.sv
// ----------------------------------------------------------------------------
// tod_if: request and result channel interfaces
// Valid/ready channels carrying the time keeper's requests and results.
// ----------------------------------------------------------------------------
interface tod_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [33:0] server_posix_sec;
	logic [29:0] server_nsec;
	logic [63:0] mono_ns;

	modport source (output valid, req_type, server_posix_sec, server_nsec, mono_ns,
		input ready);
	modport sink (input valid, req_type, server_posix_sec, server_nsec, mono_ns,
		output ready);
endinterface

interface tod_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        is_synced;
	logic [31:0] time_sec;
	logic [29:0] time_nsec;

	modport source (output valid, status, is_synced, time_sec, time_nsec, input ready);
	modport sink (input valid, status, is_synced, time_sec, time_nsec, output ready);
endinterface

### hw/rtl/tod_front.sv
// ----------------------------------------------------------------------------
// tod_front: request intake and classification
// Checks sample validity, converts to epoch seconds and registers the item.
// ----------------------------------------------------------------------------
module tod_front
	import tod_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	tod_req_if.sink   req,
	output logic      item_valid,
	output tod_item_t item,
	input  logic      item_ready
);

	logic        valid_s1;
	tod_item_t   item_s1;
	logic [33:0] epoch_sec;
	logic        bad_time;
	tod_item_t   item_d;

	assign req.ready = !valid_s1 || item_ready;

	assign epoch_sec = req.server_posix_sec - POSIX_AT_1990;
	assign bad_time  = (req.server_posix_sec <= POSIX_AT_1990) || (epoch_sec[33:32] != 2'b00)
		|| (req.server_nsec >= NS_PER_SEC);

	always_comb begin
		item_d.tsec = epoch_sec[31:0];
		item_d.tns  = req.server_nsec;
		item_d.mono = req.mono_ns;
		unique case (req.req_type)
			REQ_READ: item_d.cls = CL_READ;
			REQ_SYNC: item_d.cls = bad_time ? CL_BAD : CL_SYNC;
			REQ_FAIL: item_d.cls = CL_FAIL;
			default:  item_d.cls = CL_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= item_d;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

### hw/rtl/tod_fifo.sv
// ----------------------------------------------------------------------------
// tod_fifo: two-entry queue between front and back end
// Lets the intake and the execution side stall independently.
// ----------------------------------------------------------------------------
module tod_fifo
	import tod_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	input  tod_item_t wr_item,
	output logic      wr_ready,
	output logic      rd_valid,
	output tod_item_t rd_item,
	input  logic      rd_pop
);

	tod_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			if (do_wr && !do_rd) count_q <= count_q + 2'd1;
			else if (do_rd && !do_wr) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

### hw/rtl/tod_back.sv
// ----------------------------------------------------------------------------
// tod_back: clock state and request execution
// Holds the time state, runs the advance divide and sync step, drives results.
// ----------------------------------------------------------------------------
module tod_back
	import tod_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic [7:0] retry_limit,
	input  logic      item_valid,
	input  tod_item_t item,
	output logic      item_pop,
	tod_rsp_if.source rsp
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SKIP = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_ADD  = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_SET  = 3'd5;

	logic [2:0]  state_q;
	logic        synced_q;
	logic [15:0] fail_q;
	logic [31:0] last_sec_q;
	logic [29:0] last_nsec_q;
	logic [31:0] clk_sec_q;
	logic [29:0] clk_nsec_q;
	logic [63:0] clk_mono_q;
	logic [63:0] skip_q;

	logic [63:0] rem_q;
	logic [31:0] quo_q;
	logic [4:0]  k_q;
	logic [63:0] mono_q;
	logic [31:0] tsec_q;
	logic [29:0] tns_q;
	logic [62:0] tfull_q;
	logic [62:0] cfull_q;

	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic        out_synced_q;
	logic [31:0] out_sec_q;
	logic [29:0] out_nsec_q;

	logic        out_free;
	logic [15:0] fail_inc;
	logic        not_later;
	logic [63:0] since_net;
	logic [5:0]  shamt;
	logic [65:0] rem_x, t1, t2, t3;
	logic [1:0]  digit;
	logic [65:0] rem_next;
	logic [30:0] ns_sum;
	logic        ns_wrap;
	logic [29:0] ns_new;
	logic [31:0] sec_new;

	assign out_free = !out_valid_q || rsp.ready;
	assign item_pop = (state_q == S_IDLE) && item_valid && out_free;

	assign fail_inc  = (fail_q == 16'hFFFF) ? fail_q : fail_q + 16'd1;
	assign not_later = (item.tsec < last_sec_q)
		|| ((item.tsec == last_sec_q) && (item.tns <= last_nsec_q));
	assign since_net = rem_q - skip_q;

	// One radix-4 quotient digit per cycle against shifted multiples of 1e9.
	assign shamt = {k_q, 1'b0};
	assign rem_x = {2'b00, rem_q};
	assign t1    = {36'd0, NS_PER_SEC} << shamt;
	assign t2    = t1 << 1;
	assign t3    = t1 + t2;
	always_comb begin
		if (rem_x >= t3) begin
			digit = 2'd3; rem_next = rem_x - t3;
		end else if (rem_x >= t2) begin
			digit = 2'd2; rem_next = rem_x - t2;
		end else if (rem_x >= t1) begin
			digit = 2'd1; rem_next = rem_x - t1;
		end else begin
			digit = 2'd0; rem_next = rem_x;
		end
	end

	assign ns_sum  = {1'b0, clk_nsec_q} + {1'b0, rem_q[29:0]};
	assign ns_wrap = ns_sum >= {1'b0, NS_PER_SEC};
	assign ns_new  = ns_wrap ? 30'(ns_sum - {1'b0, NS_PER_SEC}) : ns_sum[29:0];
	assign sec_new = clk_sec_q + quo_q + {31'd0, ns_wrap};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			synced_q    <= 1'b0;
			fail_q      <= 16'd0;
			last_sec_q  <= 32'd0;
			last_nsec_q <= 30'd0;
			clk_sec_q   <= 32'd0;
			clk_nsec_q  <= 30'd0;
			clk_mono_q  <= 64'd0;
			skip_q      <= 64'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (item_pop) begin
						case (item.cls)
							CL_READ: begin
								if (!synced_q) begin
									out_valid_q  <= 1'b1;
									out_status_q <= STAT_NOSYNC;
									out_synced_q <= 1'b0;
									out_sec_q    <= 32'd0;
									out_nsec_q   <= 30'd0;
								end else begin
									state_q <= S_SKIP;
								end
							end
							CL_SYNC: begin
								if (not_later && synced_q) begin
									synced_q     <= 1'b0;
									out_valid_q  <= 1'b1;
									out_status_q <= STAT_NOTLATER;
									out_synced_q <= 1'b0;
									out_sec_q    <= clk_sec_q;
									out_nsec_q   <= clk_nsec_q;
								end else begin
									fail_q  <= 16'd0;
									state_q <= S_MUL;
								end
							end
							CL_BAD: begin
								synced_q     <= 1'b0;
								out_valid_q  <= 1'b1;
								out_status_q <= STAT_BADTIME;
								out_synced_q <= 1'b0;
								out_sec_q    <= clk_sec_q;
								out_nsec_q   <= clk_nsec_q;
							end
							CL_FAIL: begin
								fail_q       <= fail_inc;
								if (fail_inc > {8'd0, retry_limit}) synced_q <= 1'b0;
								out_valid_q  <= 1'b1;
								out_status_q <= STAT_FAILED;
								out_synced_q <= synced_q && !(fail_inc > {8'd0, retry_limit});
								out_sec_q    <= clk_sec_q;
								out_nsec_q   <= clk_nsec_q;
							end
							default: begin
								out_valid_q  <= 1'b1;
								out_status_q <= synced_q ? STAT_OK : STAT_NOSYNC;
								out_synced_q <= synced_q;
								out_sec_q    <= clk_sec_q;
								out_nsec_q   <= clk_nsec_q;
							end
						endcase
					end
				end
				S_SKIP: begin
					state_q <= S_IDLE;
					if (skip_q > rem_q || since_net == 64'd0) begin
						if (skip_q <= rem_q) skip_q <= 64'd0;
						out_valid_q  <= 1'b1;
						out_status_q <= STAT_OK;
						out_synced_q <= 1'b1;
						out_sec_q    <= clk_sec_q;
						out_nsec_q   <= clk_nsec_q;
					end else begin
						skip_q  <= 64'd0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (k_q == 5'd0) state_q <= S_ADD;
				end
				S_ADD: begin
					clk_nsec_q   <= ns_new;
					clk_sec_q    <= sec_new;
					clk_mono_q   <= mono_q;
					out_valid_q  <= 1'b1;
					out_status_q <= STAT_OK;
					out_synced_q <= 1'b1;
					out_sec_q    <= sec_new;
					out_nsec_q   <= ns_new;
					state_q      <= S_IDLE;
				end
				S_MUL: begin
					state_q <= S_SET;
				end
				S_SET: begin
					skip_q       <= (tfull_q >= cfull_q) ? 64'd0 : {1'b0, cfull_q - tfull_q};
					clk_mono_q   <= mono_q;
					clk_sec_q    <= tsec_q;
					clk_nsec_q   <= tns_q;
					last_sec_q   <= tsec_q;
					last_nsec_q  <= tns_q;
					synced_q     <= 1'b1;
					out_valid_q  <= 1'b1;
					out_status_q <= STAT_OK;
					out_synced_q <= 1'b1;
					out_sec_q    <= tsec_q;
					out_nsec_q   <= tns_q;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (item_pop) begin
			rem_q  <= item.mono - clk_mono_q;
			mono_q <= item.mono;
			tsec_q <= item.tsec;
			tns_q  <= item.tns;
		end
		if (state_q == S_SKIP) begin
			rem_q <= since_net;
			quo_q <= 32'd0;
			k_q   <= DIV_LAST;
		end
		if (state_q == S_DIV) begin
			rem_q <= rem_next[63:0];
			quo_q <= {quo_q[29:0], digit};
			k_q   <= k_q - 5'd1;
		end
		if (state_q == S_MUL) begin
			tfull_q <= 63'(62'(tsec_q) * 62'(NS_PER_SEC)) + {33'd0, tns_q};
			cfull_q <= 63'(62'(clk_sec_q) * 62'(NS_PER_SEC)) + {33'd0, clk_nsec_q};
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.is_synced = out_synced_q;
	assign rsp.time_sec  = out_sec_q;
	assign rsp.time_nsec = out_nsec_q;

endmodule

### hw/rtl/synced_time_of_day_keeper.sv
// ----------------------------------------------------------------------------
// synced_time_of_day_keeper: server-disciplined time-of-day clock
// Top level joining intake, request queue, execution back end and APB register.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (valid/ready): read the time, deliver a
// server time sample, or report a failed server request, each with the value
// of the free-running nanosecond counter. Every request yields exactly one
// result on the rsp channel: a status, the synchronized flag and the time of
// day in seconds past the 1990 epoch plus nanoseconds.
// The front end classifies a request and registers it, then places it in a
// two-entry queue; the back end executes it and holds the result in an
// output register. Failures, bad samples and unsynchronized reads are
// answered from the idle state, so they stream at one request per cycle
// while the receiver takes each result. A sample that sets the clock runs
// two constant multiplies in the multiply state, then the skip subtract in
// the set state. A synchronized read passes the skip, divide and add states:
// the elapsed time is split into seconds and nanoseconds by a radix-4 divide
// by 1e9 that retires one quotient digit per cycle over 18 digits. A
// synchronized read that leaves the clock as it is, because a pending skip
// covers the elapsed time or none has elapsed, is answered from the skip state.
// When the receiver stalls, the output register holds its result and the
// queue and front end keep taking requests until they fill. Reset clears the
// clock state, drops synchronization and sets retry_limit to 4; the APB
// register retry_limit sits at byte address 0.
// ----------------------------------------------------------------------------
module synced_time_of_day_keeper
	import tod_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tod_req_if.sink     req,
	tod_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] retry_limit_q;
	logic       front_valid;
	tod_item_t  front_item;
	logic       front_ready;
	logic       q_valid;
	tod_item_t  q_item;
	logic       q_pop;
	logic       reg_hit;

	// Only one register: byte address 0 (word index 0).
	assign reg_hit = (paddr[2] == CFG_RETRY_LIMIT[0]);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? {24'd0, retry_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= 8'd4;
		end else if (psel && penable && pwrite && reg_hit) begin
			retry_limit_q <= pwdata[7:0];
		end
	end

	tod_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.item_valid (front_valid),
		.item       (front_item),
		.item_ready (front_ready)
	);

	tod_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_item  (front_item),
		.wr_ready (front_ready),
		.rd_valid (q_valid),
		.rd_item  (q_item),
		.rd_pop   (q_pop)
	);

	tod_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.retry_limit (retry_limit_q),
		.item_valid  (q_valid),
		.item        (q_item),
		.item_pop    (q_pop),
		.rsp         (rsp)
	);

endmodule
